// ===== hw/rtl/fpmul_pkg.sv =====
// Package for the binary32/binary16 multiplier: constants, codes and stage types.
// Used by every module under hw/rtl; depends on nothing.
package fpmul_pkg;

    localparam int OperandWidth = 32;
    localparam int Frac32 = 23;
    localparam int Frac16 = 10;
    localparam int Bias32 = 127;
    localparam int Bias16 = 15;
    localparam int Emax32 = 255;
    localparam int Emax16 = 31;
    localparam int SigWidth = Frac32 + 1;
    localparam int ProdWidth = 2 * SigWidth;
    localparam int ExpWidth = 11;

    localparam logic [0:0] CfgPrecision = 1'b0;
    localparam logic [0:0] CfgRounding = 1'b1;

    typedef enum logic [1:0] {
        RND_ZERO = 2'd0,
        RND_NEAR = 2'd1,
        RND_POS  = 2'd2,
        RND_NEG  = 2'd3
    } round_t;

    typedef logic signed [ExpWidth-1:0] exp_t;

    // Decoded operands after the first stage.
    typedef struct packed {
        logic                half;
        round_t              rnd;
        logic                sign;
        logic                special;
        logic [31:0]         special_bits;
        logic [SigWidth-1:0] sig_a;
        logic [SigWidth-1:0] sig_b;
        exp_t                exp_sum;
    } dec_t;

    // Product and exponent after the multiply stage.
    typedef struct packed {
        logic                 half;
        round_t               rnd;
        logic                 sign;
        logic                 special;
        logic [31:0]          special_bits;
        logic [ProdWidth-1:0] prod;
        exp_t                 exp_sum;
    } mul_t;

    // Aligned value ahead of rounding.
    typedef struct packed {
        logic        half;
        round_t      rnd;
        logic        sign;
        logic        special;
        logic [31:0] special_bits;
        logic        ovf;
        logic [7:0]  base;
        logic [24:0] kept;
        logic        guard;
        logic        sticky;
    } aln_t;

    function automatic logic [31:0] ovf_bits(input logic half, input round_t rnd,
                                             input logic sign);
        logic [31:0] inf_v;
        logic [31:0] max_v;
        logic [31:0] sgn;
        logic        to_inf;
        inf_v = half ? 32'(Emax16 << Frac16) : 32'(Emax32 << Frac32);
        max_v = inf_v - 32'd1;
        sgn = !sign ? 32'd0 : (half ? 32'h0000_8000 : 32'h8000_0000);
        case (rnd)
            RND_ZERO: to_inf = 1'b0;
            RND_POS:  to_inf = !sign;
            RND_NEG:  to_inf = sign;
            default:  to_inf = 1'b1;
        endcase
        return sgn | (to_inf ? inf_v : max_v);
    endfunction

endpackage

// ===== hw/rtl/fpmul_stream_if.sv =====
// Valid/ready channel interface carrying one payload item.
// Depends on nothing; payload width is set per instance.
interface fpmul_stream_if #(parameter int Width = 32);
    logic             valid;
    logic             ready;
    logic [Width-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fpmul_cfg_if.sv =====
// Configuration write channel interface: register index and write data.
// Depends on nothing.
interface fpmul_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/fpmul_decode.sv =====
// Operand decode: special cases, subnormal normalization and exponent sum.
// Depends on fpmul_pkg.
module fpmul_decode
    import fpmul_pkg::*;
(
    input  logic        half,
    input  round_t      rnd,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output dec_t        dec
);

    // Returns the significand with the hidden bit at bit 23 and its exponent.
    function automatic logic [SigWidth+ExpWidth-1:0] norm(input logic hf,
                                                          input logic [31:0] x);
        logic [7:0]          e;
        logic [22:0]         f;
        logic [SigWidth-1:0] s;
        logic [4:0]          lz;
        exp_t                ex;
        if (hf) begin
            e = {3'd0, x[14:10]};
            f = {x[9:0], 13'd0};
        end else begin
            e = x[30:23];
            f = x[22:0];
        end
        lz = 5'd0;
        for (int i = 22; i >= 0; i--) begin
            if (f[i] && lz == 5'd0 && f[22:0] >> (i + 1) == 23'd0)
                lz = 5'(23 - i);
        end
        if (e != 8'd0) begin
            s = {1'b1, f};
            ex = exp_t'(e);
        end else begin
            s = {f, 1'b0} << (lz - 5'd1);
            ex = exp_t'(1) - exp_t'(lz);
        end
        return {s, ex};
    endfunction

    logic [31:0] a;
    logic [31:0] b;
    logic        sa, sb, sgn;
    logic [7:0]  ea, eb, emax;
    logic        fa_nz, fb_nz;
    logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
    logic [31:0] sgn_bits, inf_bits, qnan;
    logic [SigWidth+ExpWidth-1:0] na, nb;

    always_comb
    begin
        a = half ? {16'd0, operand_a[15:0]} : operand_a;
        b = half ? {16'd0, operand_b[15:0]} : operand_b;
        sa = half ? a[15] : a[31];
        sb = half ? b[15] : b[31];
        sgn = sa ^ sb;
        ea = half ? {3'd0, a[14:10]} : a[30:23];
        eb = half ? {3'd0, b[14:10]} : b[30:23];
        emax = half ? 8'(Emax16) : 8'(Emax32);
        fa_nz = half ? (a[9:0] != 10'd0) : (a[22:0] != 23'd0);
        fb_nz = half ? (b[9:0] != 10'd0) : (b[22:0] != 23'd0);
        nan_a = ea == emax && fa_nz;
        nan_b = eb == emax && fb_nz;
        inf_a = ea == emax && !fa_nz;
        inf_b = eb == emax && !fb_nz;
        zero_a = ea == 8'd0 && !fa_nz;
        zero_b = eb == 8'd0 && !fb_nz;
        sgn_bits = !sgn ? 32'd0 : (half ? 32'h0000_8000 : 32'h8000_0000);
        inf_bits = half ? 32'(Emax16 << Frac16) : 32'(Emax32 << Frac32);
        qnan = half ? 32'h0000_7E00 : 32'h7FC0_0000;
        na = norm(half, a);
        nb = norm(half, b);

        dec.half = half;
        dec.rnd = rnd;
        dec.sign = sgn;
        dec.sig_a = na[SigWidth+ExpWidth-1:ExpWidth];
        dec.sig_b = nb[SigWidth+ExpWidth-1:ExpWidth];
        dec.exp_sum = exp_t'(na[ExpWidth-1:0]) + exp_t'(nb[ExpWidth-1:0])
                      - (half ? exp_t'(Bias16) : exp_t'(Bias32));
        dec.special = 1'b1;
        if (nan_a || nan_b || (inf_a && zero_b) || (inf_b && zero_a))
            dec.special_bits = qnan;
        else if (inf_a || inf_b)
            dec.special_bits = sgn_bits | inf_bits;
        else if (zero_a || zero_b)
            dec.special_bits = sgn_bits;
        else
        begin
            dec.special = 1'b0;
            dec.special_bits = 32'd0;
        end
    end

endmodule

// ===== hw/rtl/fpmul_align.sv =====
// Alignment: product normalization, exponent check and right shift for tiny results.
// Depends on fpmul_pkg.
module fpmul_align
    import fpmul_pkg::*;
(
    input  mul_t mul,
    output aln_t aln
);

    logic                 top;
    exp_t                 e;
    logic [5:0]           sh;
    logic [ProdWidth-1:0] p;
    logic [ProdWidth:0]   shifted;
    logic [ProdWidth-1:0] lost;
    exp_t                 emax;

    always_comb
    begin
        // Binary16 significands sit at bit 23 too, so the product carries 26 extra zeros.
        p = mul.prod;
        top = p[ProdWidth-1];
        e = mul.exp_sum + (top ? exp_t'(1) : exp_t'(0));
        emax = mul.half ? exp_t'(Emax16) : exp_t'(Emax32);
        sh = top ? 6'd24 : 6'd23;
        if (e < exp_t'(1))
        begin
            if (exp_t'(1) - e > exp_t'(26))
                sh = 6'd50;
            else
                sh = sh + 6'(exp_t'(1) - e);
        end
        if (mul.half)
            sh = sh + 6'd13;
        shifted = {1'b0, p} >> sh;
        lost = p & ((48'd1 << sh) - 48'd1);
        aln.half = mul.half;
        aln.rnd = mul.rnd;
        aln.sign = mul.sign;
        aln.special = mul.special;
        aln.special_bits = mul.special_bits;
        aln.ovf = e >= emax;
        aln.base = (e >= exp_t'(1)) ? 8'(e - exp_t'(1)) : 8'd0;
        aln.kept = shifted[24:0];
        // A round bit above the top of the product is zero.
        aln.guard = (sh == 6'd0 || sh > 6'd48) ? 1'b0 : p[sh - 6'd1];
        aln.sticky = (lost & ~(48'd1 << (sh - 6'd1))) != 48'd0;
    end

endmodule

// ===== hw/rtl/fpmul_round.sv =====
// Rounding and final encoding, including overflow by rounding mode.
// Depends on fpmul_pkg.
module fpmul_round
    import fpmul_pkg::*;
(
    input  aln_t        aln,
    output logic [31:0] product_bits
);

    logic        up;
    logic        inexact;
    logic [31:0] bits;
    logic [31:0] inf_v;
    logic [31:0] sgn;

    always_comb
    begin
        inexact = aln.guard || aln.sticky;
        case (aln.rnd)
            RND_NEAR: up = aln.guard && (aln.sticky || aln.kept[0]);
            RND_POS:  up = inexact && !aln.sign;
            RND_NEG:  up = inexact && aln.sign;
            default:  up = 1'b0;
        endcase
        inf_v = aln.half ? 32'(Emax16 << Frac16) : 32'(Emax32 << Frac32);
        sgn = !aln.sign ? 32'd0 : (aln.half ? 32'h0000_8000 : 32'h8000_0000);
        bits = (aln.half ? ({24'd0, aln.base} << Frac16) : ({24'd0, aln.base} << Frac32))
               + {7'd0, aln.kept} + {31'd0, up};
        if (aln.special)
            product_bits = aln.special_bits;
        else if (aln.ovf || bits >= inf_v)
            product_bits = ovf_bits(aln.half, aln.rnd, aln.sign);
        else
            product_bits = sgn | bits;
    end

endmodule

// ===== hw/rtl/fp_multiplier_half_single.sv =====
// Top level of the binary32/binary16 floating-point multiplier pipeline.
// Depends on fpmul_pkg, the channel interfaces, and the decode, align and round modules.
//
// Usage: operand pairs arrive on the in_ch channel (operand_a in bits 31:0 of the
// payload, operand_b in bits 63:32) and each item yields exactly one product on
// out_ch. The cfg channel writes precision_mode (index 0) and rounding_mode
// (index 1); it is always ready and should only be written while the pipe is empty.
// In binary16 mode only the low 16 bits of each operand are used, and the upper
// half of the product is zero.
//
// The pipe has four register stages: decode, 24x24 multiply, alignment and
// rounding, and each item passes them in that order before its product is valid
// on out_ch. One item can enter every cycle while out_ch is not stalled. Each
// stage advances when the stage after it is empty or moving, so a stalled
// receiver holds the results in place and backpressure reaches in_ch.ready
// without losing or repeating any item.
// Reset clears all valid bits and sets binary32 with nearest-even rounding.
module fp_multiplier_half_single
    import fpmul_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    fpmul_cfg_if.sink            cfg,
    fpmul_stream_if.sink         in_ch,
    fpmul_stream_if.source       out_ch
);

    logic        half_reg;
    round_t      rnd_reg;
    logic [3:0]  valid_reg;
    logic [3:0]  adv;
    dec_t        dec_next, dec_reg;
    mul_t        mul_reg;
    aln_t        aln_next, aln_reg;
    logic [31:0] prod_next, prod_reg;

    assign cfg.ready = 1'b1;

    // Stage i loads when it is empty or its content moves on.
    assign adv[3] = !valid_reg[3] || out_ch.ready;
    assign adv[2] = !valid_reg[2] || adv[3];
    assign adv[1] = !valid_reg[1] || adv[2];
    assign adv[0] = !valid_reg[0] || adv[1];
    assign in_ch.ready = adv[0];

    fpmul_decode u_decode (
        .half      (half_reg),
        .rnd       (rnd_reg),
        .operand_a (in_ch.data[31:0]),
        .operand_b (in_ch.data[63:32]),
        .dec       (dec_next)
    );

    fpmul_align u_align (
        .mul (mul_reg),
        .aln (aln_next)
    );

    fpmul_round u_round (
        .aln          (aln_reg),
        .product_bits (prod_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
            rnd_reg <= RND_NEAR;
            valid_reg <= 4'd0;
        end
        else
        begin
            if (cfg.valid)
            begin
                if (cfg.index == CfgPrecision)
                    half_reg <= cfg.data[0];
                else
                    rnd_reg <= round_t'(cfg.data);
            end
            if (adv[0]) valid_reg[0] <= in_ch.valid;
            if (adv[1]) valid_reg[1] <= valid_reg[0];
            if (adv[2]) valid_reg[2] <= valid_reg[1];
            if (adv[3]) valid_reg[3] <= valid_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
            dec_reg <= dec_next;
        if (adv[1])
        begin
            mul_reg.half <= dec_reg.half;
            mul_reg.rnd <= dec_reg.rnd;
            mul_reg.sign <= dec_reg.sign;
            mul_reg.special <= dec_reg.special;
            mul_reg.special_bits <= dec_reg.special_bits;
            mul_reg.exp_sum <= dec_reg.exp_sum;
            mul_reg.prod <= dec_reg.sig_a * dec_reg.sig_b;
        end
        if (adv[2])
            aln_reg <= aln_next;
        if (adv[3])
            prod_reg <= prod_next;
    end

    assign out_ch.valid = valid_reg[3];
    assign out_ch.data = prod_reg;

endmodule

// ===== tb/fpmul_checker.sv =====
// Checker for the floating-point multiplier: watches the input, output and configuration channels.
// It predicts each product and compares it with the block's output.
// Depends on fpmul_pkg only; the channels come in as plain signals.
`timescale 1ns / 1ps
module fpmul_checker
    import fpmul_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_index,
    input  logic [1:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [63:0] in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] out_data,
    output int          fail_count,
    output int          pending
);

    logic        half_mode;
    round_t      rnd_mode;
    logic [31:0] expected_products[$];

    // Brings a finite nonzero operand to a significand with the hidden bit at bit m.
    function automatic logic [63:0] norm_sig(input int fexp, input logic [31:0] frac,
                                             input int m, output int eo);
        logic [63:0] s;
        s = {32'd0, frac};
        if (fexp != 0)
        begin
            s = s | (64'd1 << m);
            eo = fexp;
        end
        else
        begin
            eo = 1;
            while (s[m] == 1'b0)
            begin
                s = s << 1;
                eo = eo - 1;
            end
        end
        return s;
    endfunction

    function automatic logic [31:0] product_of(input logic [31:0] a_in,
                                               input logic [31:0] b_in);
        int          m, bias, emax, ea, eb, xa, xb, e, sh;
        logic [31:0] a, b, fmask, sbit, qnan, infb, maxb, fa, fb, osign, base;
        logic        sg, up;
        logic [63:0] ma, mb, prod, kept, rem, halfway, bits;
        m = half_mode ? Frac16 : Frac32;
        bias = half_mode ? Bias16 : Bias32;
        emax = half_mode ? Emax16 : Emax32;
        a = half_mode ? (a_in & 32'hFFFF) : a_in;
        b = half_mode ? (b_in & 32'hFFFF) : b_in;
        fmask = (32'd1 << m) - 1;
        sbit = half_mode ? 32'h8000 : 32'h8000_0000;
        infb = emax << m;
        maxb = infb - 1;
        qnan = infb | (32'd1 << (m - 1));
        sg = ((a & sbit) != 0) ^ ((b & sbit) != 0);
        osign = sg ? sbit : 32'd0;
        ea = (a >> m) & emax;
        eb = (b >> m) & emax;
        fa = a & fmask;
        fb = b & fmask;
        if ((ea == emax && fa != 0) || (eb == emax && fb != 0) ||
            (ea == emax && eb == 0 && fb == 0) || (eb == emax && ea == 0 && fa == 0))
            return qnan;
        if (ea == emax || eb == emax)
            return osign | infb;
        if ((ea == 0 && fa == 0) || (eb == 0 && fb == 0))
            return osign;
        ma = norm_sig(ea, fa, m, xa);
        mb = norm_sig(eb, fb, m, xb);
        prod = ma * mb;
        e = xa + xb - bias;
        sh = m;
        if ((prod >> (2 * m + 1)) != 0)
        begin
            e = e + 1;
            sh = sh + 1;
        end
        up = 1'b0;
        if (e < emax)
        begin
            if (e >= 1)
                base = e - 1;
            else
            begin
                base = 0;
                sh = (sh + 1 - e > 63) ? 63 : sh + 1 - e;
            end
            kept = prod >> sh;
            rem = prod & ((64'd1 << sh) - 1);
            halfway = 64'd1 << (sh - 1);
            case (rnd_mode)
                RND_NEAR: up = rem > halfway || (rem == halfway && kept[0]);
                RND_POS:  up = rem != 0 && !sg;
                RND_NEG:  up = rem != 0 && sg;
                default:  up = 1'b0;
            endcase
            bits = ({32'd0, base} << m) + kept + up;
            if (bits < {32'd0, infb})
                return osign | bits[31:0];
        end
        case (rnd_mode)
            RND_ZERO: return osign | maxb;
            RND_POS:  return osign | (sg ? maxb : infb);
            RND_NEG:  return osign | (sg ? infb : maxb);
            default:  return osign | infb;
        endcase
    endfunction

    assign pending = expected_products.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_mode <= 1'b0;
            rnd_mode <= RND_NEAR;
            fail_count <= 0;
            expected_products.delete();
        end
        else
        begin
            // Products are predicted with the settings in force before this edge.
            if (in_valid && in_ready)
                expected_products.push_back(product_of(in_data[31:0], in_data[63:32]));
            if (out_valid && out_ready)
            begin
                if (expected_products.size() == 0)
                begin
                    $display("%0t: unexpected product %h", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else if (expected_products[0] !== out_data)
                begin
                    $display("%0t: product expected %h actual %h", $time,
                             expected_products[0], out_data);
                    fail_count <= fail_count + 1;
                    void'(expected_products.pop_front());
                end
                else
                    void'(expected_products.pop_front());
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CfgPrecision)
                    half_mode <= cfg_data[0];
                else
                    rnd_mode <= round_t'(cfg_data);
            end
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench top for fp_multiplier_half_single: clock, reset, stimulus and verdict.
// Depends on fpmul_pkg, the channel interfaces and fpmul_checker.
`timescale 1ns / 1ps
module tb;
    import fpmul_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending;

    fpmul_cfg_if              cfg ();
    fpmul_stream_if #(64)     in_ch ();
    fpmul_stream_if #(32)     out_ch ();

    fp_multiplier_half_single dut (.clk(clk), .rst_n(rst_n), .cfg(cfg),
                                   .in_ch(in_ch), .out_ch(out_ch));

    fpmul_checker chk (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg.valid), .cfg_ready(cfg.ready),
        .cfg_index(cfg.index), .cfg_data(cfg.data),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .fail_count(fail_count), .pending(pending)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Drive everything to a known value before the first edge.
    initial
    begin
        cfg.valid = 1'b0;
        cfg.index = CfgPrecision;
        cfg.data = 2'd0;
        in_ch.valid = 1'b0;
        in_ch.data = 64'd0;
        out_ch.ready = 1'b0;
    end

    // Receiver: holds ready low for a random number of cycles before each item.
    // For a random quarter of the items the stall is skipped so that back-to-back stretches occur.
    initial
    begin
        int gap;
        @(posedge clk iff rst_n);
        forever
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk iff out_ch.valid);
        end
    end

    // Safety limit far beyond the slowest correct run.
    initial
    begin
        #8_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Writes one register and waits for its acceptance.
    task automatic write_reg(input logic [0:0] idx, input logic [1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk iff cfg.ready);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Sends one operand pair, with an optional random gap ahead of it.
    task automatic send_pair(input logic [31:0] a, input logic [31:0] b, input bit gaps);
        int gap;
        gap = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= {b, a};
        @(posedge clk iff in_ch.ready);
    endtask

    // Lets the pipe drain so the configuration can change safely.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk iff pending == 0);
        repeat (8) @(posedge clk);
    endtask

    // Random operand biased toward interesting exponents in the current precision.
    function automatic logic [31:0] pick_operand(input bit half);
        logic [31:0] v;
        int          sel;
        v = $urandom;
        sel = $urandom_range(0, 9);
        if (half)
        begin
            case (sel)
                0: v[14:10] = 5'd0;
                1: v[14:10] = 5'd31;
                2: v[14:10] = $urandom_range(1, 6);
                3: v[14:10] = $urandom_range(24, 30);
                4: v[14:0] = 15'd0;
                default: ;
            endcase
        end
        else
        begin
            case (sel)
                0: v[30:23] = 8'd0;
                1: v[30:23] = 8'd255;
                2: v[30:23] = $urandom_range(1, 30);
                3: v[30:23] = $urandom_range(200, 254);
                4: v[30:0] = 31'd0;
                5: v[30:23] = $urandom_range(100, 154);
                default: ;
            endcase
        end
        return v;
    endfunction

    initial
    begin
        logic [31:0] dir_a[14];
        logic [31:0] dir_b[14];
        bit          half;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed binary32 cases under reset settings: zero, infinity, NaN,
        // infinity times zero, subnormals, overflow, tiny results, all-ones.
        dir_a = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'h7F80_0000,
                  32'h7FC0_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'h0080_0000,
                  32'h3F80_0000, 32'hFFFF_FFFF, 32'h007F_FFFF, 32'h3F7F_FFFF,
                  32'hC000_0000, 32'h1FFF_FFFF};
        dir_b = '{32'h3F80_0000, 32'h4000_0000, 32'hC000_0000, 32'h0000_0000,
                  32'h3F80_0000, 32'h3F00_0000, 32'h7F7F_FFFF, 32'h3F00_0000,
                  32'h3F80_0001, 32'h0000_0000, 32'h3F80_0001, 32'h0080_0001,
                  32'hFF7F_FFFF, 32'h1FFF_FFFF};
        foreach (dir_a[i])
            send_pair(dir_a[i], dir_b[i], 1'b0);
        drain();

        // Directed binary16 cases, upper bits set in some to show they are ignored.
        write_reg(CfgPrecision, 2'd1);
        send_pair(32'hFFFF_7BFF, 32'h1234_7BFF, 1'b0);
        send_pair(32'h0000_0001, 32'h0000_3800, 1'b0);
        send_pair(32'hABCD_7C00, 32'h0000_0000, 1'b0);
        send_pair(32'h0000_7E01, 32'h0000_3C00, 1'b0);
        send_pair(32'h0000_FC00, 32'h0000_C000, 1'b0);
        send_pair(32'h0000_03FF, 32'h0000_3C01, 1'b0);
        send_pair(32'h0000_0400, 32'h0000_3BFF, 1'b0);
        send_pair(32'h0000_8000, 32'h0000_3C00, 1'b0);
        drain();

        // Random phases across every precision and rounding combination; the
        // drain between phases also makes the sender wait for every result.
        for (int phase = 0; phase < 16; phase++)
        begin
            half = phase[0];
            write_reg(CfgPrecision, {1'b0, half});
            write_reg(CfgRounding, phase[2:1] ^ phase[3:2]);
            repeat (58)
                send_pair(pick_operand(half), pick_operand(half), 1'b1);
            drain();
        end

        @(posedge clk iff pending == 0);
        repeat (16) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/fpmul_pkg.sv
hw/rtl/fpmul_stream_if.sv
hw/rtl/fpmul_cfg_if.sv
hw/rtl/fpmul_decode.sv
hw/rtl/fpmul_align.sv
hw/rtl/fpmul_round.sv
hw/rtl/fp_multiplier_half_single.sv
tb/fpmul_checker.sv
tb/tb.sv
